>>> sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit: op codes,
// datapath widths and the entry that passes from front to back.
// ----------------------------------------------------------------------------
package rau_pkg;

  // operand and datapath widths
  localparam int IW   = 16;   // operand field width
  localparam int PW   = 32;   // product width
  localparam int NW   = 33;   // unreduced numerator/denominator width (signed)
  localparam int MW   = 32;   // magnitude width
  localparam int RW   = 32;   // result field width
  localparam int CW   = 5;    // bit counter width for gcd shift and divide
  localparam int QDEPTH = 2;  // front-to-back queue depth

  // op codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  // one classified item handed from front to back
  typedef struct packed {
    logic                 arith;  // needs gcd reduction
    logic                 err;    // zero denominator
    logic                 eq;     // compare result: equal
    logic                 lt;     // compare result: less than
    logic signed [NW-1:0] num;
    logic signed [NW-1:0] den;
  } rau_entry_t;

endpackage

>>> sv/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front
// Accepts an item, forms the cross products, classifies the operation and
// pushes a ready-to-reduce entry into the queue.
// ----------------------------------------------------------------------------
module rau_front import rau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           op,
  input  logic signed [IW-1:0] a_num,
  input  logic signed [IW-1:0] a_den,
  input  logic signed [IW-1:0] b_num,
  input  logic signed [IW-1:0] b_den,
  output logic                 push,
  output rau_entry_t           entry,
  input  logic                 q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_CMB  = 2'd2;

  logic [1:0]           state;
  logic [2:0]           op_r;
  logic signed [IW-1:0] an, ad, bn, bd;
  logic signed [PW-1:0] pa, pb, pc, pd;

  logic                 op_ok, is_cmp, zden, flip;
  logic signed [NW-1:0] num_c, den_c;

  assign in_stall = (state != F_IDLE);

  // sequencer and operand/product registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) state <= F_MUL;
        end
        F_MUL: state <= F_CMB;
        F_CMB: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_valid) begin
      op_r <= op;
      an   <= a_num;
      ad   <= a_den;
      bn   <= b_num;
      bd   <= b_den;
    end
    if (state == F_MUL) begin
      pa <= an * bd;
      pb <= bn * ad;
      pc <= an * bn;
      pd <= ad * bd;
    end
  end

  // combine products and classify
  always_comb begin
    op_ok  = (op_r <= OP_CMP);
    is_cmp = (op_r == OP_CMP);
    zden   = (ad == '0) || (bd == '0);
    flip   = ad[IW-1] ^ bd[IW-1];
    case (op_r)
      OP_ADD: begin
        num_c = NW'(pa) + NW'(pb);
        den_c = NW'(pd);
      end
      OP_SUB: begin
        num_c = NW'(pa) - NW'(pb);
        den_c = NW'(pd);
      end
      OP_MUL: begin
        num_c = NW'(pc);
        den_c = NW'(pd);
      end
      default: begin
        num_c = NW'(pa);
        den_c = NW'(pb);
      end
    endcase
    entry.num   = num_c;
    entry.den   = den_c;
    entry.arith = op_ok && !is_cmp && !zden && (den_c != '0);
    entry.err   = op_ok && (zden || (!is_cmp && den_c == '0));
    entry.eq    = is_cmp && !zden && (pa == pb);
    entry.lt    = is_cmp && !zden && (flip ? (pa > pb) : (pa < pb));
  end

  assign push = (state == F_CMB) && !q_full;

endmodule

>>> sv/rau_queue.sv
// ----------------------------------------------------------------------------
// rau_queue
// Short queue between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module rau_queue import rau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rau_entry_t wr_entry,
  output logic       full,
  input  logic       pop,
  output rau_entry_t rd_entry,
  output logic       empty
);

  localparam int AW = $clog2(QDEPTH);

  rau_entry_t     mem [QDEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;

  assign full     = (count == (AW+1)'(QDEPTH));
  assign empty    = (count == '0);
  assign rd_entry = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");

endmodule

>>> sv/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back
// Reduces a fraction by the gcd of its magnitudes: binary gcd one step a
// cycle, then two restoring dividers in parallel, then sign and saturation.
// ----------------------------------------------------------------------------
module rau_back import rau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  rau_entry_t           q_entry,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [RW-1:0] res_num,
  output logic signed [RW-1:0] res_den,
  output logic                 is_equal,
  output logic                 is_less,
  output logic                 zero_den_error
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_GCD  = 3'd1;
  localparam logic [2:0] B_DIV  = 3'd2;
  localparam logic [2:0] B_FIN  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]    state;
  logic          neg_n, neg_d;
  logic [MW-1:0] mn, md, ga, gb, g, qn, qd;
  logic [CW-1:0] k, cnt;
  logic [MW:0]   rn, rd;

  logic [MW:0]   tn, td;
  logic          bn_q, bd_q;

  // saturate to the result width
  function automatic logic [RW-1:0] sat(input logic signed [MW+1:0] v);
    logic signed [MW+1:0] hi, lo;
    hi = (MW+2)'({1'b0, {(RW-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi)      sat = {1'b0, {(RW-1){1'b1}}};
    else if (v < lo) sat = {1'b1, {(RW-1){1'b0}}};
    else             sat = v[RW-1:0];
  endfunction

  assign pop = (state == B_IDLE) && !q_empty;

  // trial subtraction for both dividers
  always_comb begin
    tn   = {rn[MW-1:0], qn[MW-1]};
    td   = {rd[MW-1:0], qd[MW-1]};
    bn_q = (tn >= {1'b0, g});
    bd_q = (td >= {1'b0, g});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            if (q_entry.arith) begin
              state <= B_GCD;
            end else begin
              state     <= B_OUT;
              out_valid <= 1'b1;
            end
          end
        end
        B_GCD: begin
          if (ga == '0) state <= B_DIV;
        end
        B_DIV: begin
          if (cnt == '1) state <= B_FIN;
        end
        B_FIN: begin
          state     <= B_OUT;
          out_valid <= 1'b1;
        end
        B_OUT: begin
          if (!out_stall) begin
            state     <= B_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          neg_n          <= q_entry.num[NW-1];
          neg_d          <= q_entry.den[NW-1];
          mn             <= q_entry.num[NW-1] ? MW'(-q_entry.num) : MW'(q_entry.num);
          md             <= q_entry.den[NW-1] ? MW'(-q_entry.den) : MW'(q_entry.den);
          ga             <= q_entry.num[NW-1] ? MW'(-q_entry.num) : MW'(q_entry.num);
          gb             <= q_entry.den[NW-1] ? MW'(-q_entry.den) : MW'(q_entry.den);
          k              <= '0;
          res_num        <= '0;
          res_den        <= '0;
          is_equal       <= q_entry.eq;
          is_less        <= q_entry.lt;
          zero_den_error <= q_entry.err;
        end
      end
      B_GCD: begin
        // binary gcd step
        if (ga == '0) begin
          g   <= gb << k;
          qn  <= mn;
          qd  <= md;
          rn  <= '0;
          rd  <= '0;
          cnt <= '0;
        end else if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          k  <= k + 1'b1;
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (ga >= gb) begin
          ga <= (ga - gb) >> 1;
        end else begin
          gb <= (gb - ga) >> 1;
        end
      end
      B_DIV: begin
        // one quotient bit per cycle on both parts
        rn  <= bn_q ? (tn - {1'b0, g}) : tn;
        rd  <= bd_q ? (td - {1'b0, g}) : td;
        qn  <= {qn[MW-2:0], bn_q};
        qd  <= {qd[MW-2:0], bd_q};
        cnt <= cnt + 1'b1;
      end
      B_FIN: begin
        res_num <= sat(neg_n ? -$signed({2'b00, qn}) : $signed({2'b00, qn}));
        res_den <= sat(neg_d ? -$signed({2'b00, qd}) : $signed({2'b00, qd}));
      end
      default: ;
    endcase
  end

  a_cmp_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_equal && is_less))
    else $error("equal and less both set");
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_den_error) |-> (res_num == '0 && res_den == '0 && !is_equal && !is_less))
    else $error("error result not cleared");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !pop)
    else $error("pop while result pending");

endmodule

>>> sv/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit
// Add, subtract, multiply, divide and compare on two fractions, with the
// arithmetic results reduced by the gcd of their magnitudes.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------
//  in       | in_valid / in_stall | op, a_num, a_den, b_num, b_den
//  out      | out_valid/out_stall | res_num, res_den, is_equal, is_less,
//           |                     | zero_den_error
//
// the front takes an item through its multiply and combine states and
// pushes it once the queue has room; compare, error and unused op codes go
// straight to the back's output state, arithmetic ops first run the binary
// gcd loop (one step a cycle) and then the two 32-step dividers.
// a 2-entry queue lets the front take new items while a result waits.
// rst is synchronous and clears all control state; no clearing pass.
module rational_arith_unit import rau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           op,
  input  logic signed [IW-1:0] a_num,
  input  logic signed [IW-1:0] a_den,
  input  logic signed [IW-1:0] b_num,
  input  logic signed [IW-1:0] b_den,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [RW-1:0] res_num,
  output logic signed [RW-1:0] res_den,
  output logic                 is_equal,
  output logic                 is_less,
  output logic                 zero_den_error
);

  logic       push, q_full, pop, q_empty;
  rau_entry_t wr_entry, rd_entry;

  // classify and cross-multiply
  rau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .a_num    (a_num),
    .a_den    (a_den),
    .b_num    (b_num),
    .b_den    (b_den),
    .push     (push),
    .entry    (wr_entry),
    .q_full   (q_full)
  );

  // decoupling queue
  rau_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .pop      (pop),
    .rd_entry (rd_entry),
    .empty    (q_empty)
  );

  // gcd reduction and result register
  rau_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_entry        (rd_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .res_num        (res_num),
    .res_den        (res_den),
    .is_equal       (is_equal),
    .is_less        (is_less),
    .zero_den_error (zero_den_error)
  );

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rational_arith_unit: a directed table of fraction
// operations, then random traffic, each result checked against the expected
// value written in the table or, where the table has none, a predictor.
module tb;
  import rau_pkg::*;

  typedef struct {
    logic [2:0]         op;
    logic signed [15:0] an, ad, bn, bd;
  } frac_req_t;

  typedef struct {
    logic signed [31:0] num, den;
    logic               eq, lt, err;
  } frac_res_t;

  typedef struct {
    frac_req_t req;
    bit        typed;   // expected result written in the table
    frac_res_t res;
  } table_row_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [2:0] op;
  logic signed [15:0] a_num, a_den, b_num, b_den;
  logic signed [31:0] res_num, res_den;
  logic is_equal, is_less, zero_den_error;

  frac_res_t pending_results[$];
  int n_mismatch;
  int idle_cycles;
  bit quiet_phase;

  rational_arith_unit u_top (
    .clk, .rst, .in_valid, .in_stall, .op, .a_num, .a_den, .b_num, .b_den,
    .out_valid, .out_stall, .res_num, .res_den, .is_equal, .is_less,
    .zero_den_error
  );

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // fraction arithmetic predictor
  function automatic frac_res_t predict_fraction(frac_req_t r);
    frac_res_t o;
    longint an, ad, bn, bd, num, den, l, rr;
    longint unsigned g;
    o = '{default: 0};
    an = r.an; ad = r.ad; bn = r.bn; bd = r.bd;
    if (r.op > OP_CMP) return o;
    if (ad == 0 || bd == 0) begin
      o.err = 1;
      return o;
    end
    if (r.op == OP_CMP) begin
      if (ad < 0) begin an = -an; ad = -ad; end
      if (bd < 0) begin bn = -bn; bd = -bd; end
      l = an * bd;
      rr = bn * ad;
      o.eq = (l == rr);
      o.lt = (l < rr);
      return o;
    end
    case (r.op)
      OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
      OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
      OP_MUL: begin num = an * bn; den = ad * bd; end
      default: begin num = an * bd; den = ad * bn; end
    endcase
    if (den == 0) begin
      o.err = 1;
      return o;
    end
    g = gcd_mag(num < 0 ? -num : num, den < 0 ? -den : den);
    num = num / longint'(g);
    den = den / longint'(g);
    o.num = clamp32(num);
    o.den = clamp32(den);
    return o;
  endfunction

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(0, 9))
      0: return 16'sd0;
      1: return 16'sd32767;
      2: return -16'sd32767;
      3: return 16'sh8000;
      4, 5: return 16'($urandom_range(0, 40)) - 16'sd20;
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transfer; pending expectation pushed at acceptance
  task automatic send_fraction(frac_req_t r, frac_res_t exp_res);
    if (!quiet_phase && $urandom_range(0, 99) < 24) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1;
    op <= r.op; a_num <= r.an; a_den <= r.ad; b_num <= r.bn; b_den <= r.bd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(exp_res);
    @(negedge clk);
  endtask

  // receiver stall
  always @(negedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= !quiet_phase && ($urandom_range(0, 99) < 24);
  end

  // result check
  always @(posedge clk) begin
    frac_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result transfer");
      end else begin
        e = pending_results.pop_front();
        if (res_num !== e.num || res_den !== e.den || is_equal !== e.eq ||
            is_less !== e.lt || zero_den_error !== e.err) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp %0d/%0d eq%0b lt%0b err%0b got %0d/%0d eq%0b lt%0b err%0b",
                     e.num, e.den, e.eq, e.lt, e.err, res_num, res_den,
                     is_equal, is_less, zero_den_error);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  table_row_t directed[] = '{
    '{'{OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3}, 1, '{32'sd5, 32'sd6, 0, 0, 0}},
    '{'{OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2}, 1, '{32'sd0, 32'sd1, 0, 0, 0}},
    '{'{OP_MUL, 16'sd2, 16'sd3, 16'sd3, 16'sd4}, 1, '{32'sd1, 32'sd2, 0, 0, 0}},
    '{'{OP_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd5}, 1, '{0, 0, 0, 0, 1}},
    '{'{OP_CMP, 16'sd1, 16'sd2, 16'sd2, 16'sd4}, 1, '{0, 0, 1, 0, 0}},
    '{'{OP_CMP, 16'sd1, -16'sd2, 16'sd1, 16'sd2}, 1, '{0, 0, 0, 1, 0}},
    '{'{OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1}, 1, '{0, 0, 0, 0, 1}},
    '{'{OP_CMP, 16'sd1, 16'sd1, 16'sd1, 16'sd0}, 1, '{0, 0, 0, 0, 1}},
    '{'{3'd5, 16'sd1, 16'sd1, 16'sd1, 16'sd1}, 1, '{0, 0, 0, 0, 0}},
    '{'{3'd7, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, '{0, 0, 0, 0, 0}},
    '{'{OP_MUL, 16'sd0, -16'sd7, 16'sd3, 16'sd5}, 0, '{default: 0}},
    '{'{OP_MUL, 16'sd32767, 16'sd1, 16'sd32767, 16'sd1}, 0, '{default: 0}},
    '{'{OP_ADD, 16'sd32767, 16'sd32767, -16'sd32767, 16'sd32767}, 0, '{default: 0}},
    '{'{OP_SUB, -16'sd32767, 16'sd1, 16'sd32767, -16'sd1}, 0, '{default: 0}},
    '{'{OP_DIV, -16'sd32767, 16'sd1, 16'sd1, 16'sd32767}, 0, '{default: 0}},
    '{'{OP_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1}, 0, '{default: 0}},
    '{'{OP_ADD, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1}, 0, '{default: 0}},
    '{'{OP_DIV, 16'sd6, -16'sd4, -16'sd9, 16'sd2}, 0, '{default: 0}},
    '{'{OP_CMP, 16'sh8000, -16'sd1, 16'sd32767, 16'sh8000}, 0, '{default: 0}},
    '{'{OP_CMP, 16'sd3, -16'sd5, -16'sd2, 16'sd5}, 0, '{default: 0}}
  };

  // stimulus
  initial begin
    frac_req_t r;
    n_mismatch = 0;
    quiet_phase = 0;
    rst = 1;
    in_valid = 0;
    op = 0; a_num = 0; a_den = 0; b_num = 0; b_den = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (directed[i])
      send_fraction(directed[i].req, directed[i].typed ? directed[i].res :
                    predict_fraction(directed[i].req));

    for (int i = 0; i < 1500; i++) begin
      quiet_phase = (i >= 600 && i < 800);
      // hold off until every pending result has drained
      if (i == 400) begin
        in_valid <= 0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
      end
      r.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) :
                                            3'($urandom_range(0, 4));
      r.an = rand_field();
      r.ad = rand_field();
      r.bn = rand_field();
      r.bd = rand_field();
      send_fraction(r, predict_fraction(r));
    end
    quiet_phase = 0;
    in_valid <= 0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/rau_pkg.sv
sv/rau_front.sv
sv/rau_queue.sv
sv/rau_back.sv
sv/rational_arith_unit.sv
test/tb.sv
